>>> rtl/core/alfr_pkg.sv
// ----------------------------------------------------------------------------
// alfr_pkg: shared types and constants of the lagged Fibonacci generator
// Ring size, lag gap, fill constants, boot words, sequencer states and the
// per-cell control struct.
// ----------------------------------------------------------------------------
package alfr_pkg;

	localparam int TABLE_DEPTH   = 31;
	localparam int LAG_GAP       = 3;
	localparam int DISCARD_COUNT = 310;

	localparam int FILL_CNT_W = $clog2(TABLE_DEPTH);
	localparam int DISC_CNT_W = $clog2(DISCARD_COUNT + 2);

	localparam logic [31:0] FILL_MUL = 32'd1103515245;
	localparam logic [31:0] FILL_ADD = 32'd12345;

	// table contents after reset, word 0 first
	localparam logic [31:0] BOOT_WORDS [TABLE_DEPTH] = '{
		-32'd1708027847, 32'd853131300,   -32'd1687801470, 32'd1570894658,
		-32'd566525472,  -32'd552964171,  -32'd251413502,  32'd1223901435,
		32'd1950999915,  -32'd1095640144, -32'd1420011240, -32'd1805298435,
		-32'd1943115761, -32'd348292705,  -32'd1323376457, 32'd759393158,
		-32'd630772182,  32'd361286280,   -32'd479628451,  -32'd1873857033,
		-32'd686452778,  32'd1873211473,  32'd1634626454,  -32'd1399525412,
		32'd910245779,   -32'd970800488,  -32'd173790536,  -32'd1970743429,
		-32'd173171442,  -32'd1986452981, 32'd670779321
	};

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FILL,
		ST_DISCARD
	} seq_state_t;

	typedef struct packed {
		logic shift_en;  // take the neighbor's word (or the alternate word)
		logic add_en;    // take the alternate word instead of the neighbor's
	} cell_ctl_t;

endpackage

>>> rtl/core/alfr_cell.sv
// ----------------------------------------------------------------------------
// alfr_cell: one word of the lag ring
// Holds one 32-bit table word and, when shifted, takes its neighbor's word
// or the alternate (sum) word.
// ----------------------------------------------------------------------------
module alfr_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        init_word,
	input  alfr_pkg::cell_ctl_t ctl,
	input  logic [31:0]        nb_word,
	input  logic [31:0]        alt_word,
	output logic [31:0]        word
);

	logic [31:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= init_word;
		end else if (ctl.shift_en) begin
			word_q <= ctl.add_en ? alt_word : nb_word;
		end
	end

	assign word = word_q;

endmodule

>>> rtl/core/additive_lagged_fibonacci_rng_unit.sv
// ----------------------------------------------------------------------------
// additive_lagged_fibonacci_rng_unit: additive lagged Fibonacci generator
// 31-word ring, lag gap 3, draw and reseed commands on one input channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command word: operation 1
//   draws a value, operation 0 reseeds from seed. Output channel
//   (out_valid/out_stall) carries one 31-bit value per draw.
//   A draw is accepted when in_stall is low and its value appears in the output
//   register on the next cycle; draws may follow each other every cycle, one
//   per cycle sustained while the receiver takes them.
//   A reseed keeps in_stall high through the fill of every ring word (one LCG
//   multiply per cycle) and the discard draws after it, and yields no word.
//   The table is a ring of cells that rotates one place per draw, so the rear
//   word always sits in cell 0 and the front word in cell 3; the rotation is
//   what advances both indices.
//   Reset clears the output valid flag and loads the ring with the boot words.
//   While the receiver stalls with a word pending, in_stall stays high and
//   the pending word holds.
// ----------------------------------------------------------------------------
module additive_lagged_fibonacci_rng_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] seed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] value
);

	localparam int DEPTH = alfr_pkg::TABLE_DEPTH;
	localparam int GAP   = alfr_pkg::LAG_GAP;

	alfr_pkg::seq_state_t state_q, state_d;

	logic [alfr_pkg::FILL_CNT_W-1:0] fill_cnt_q;
	logic [alfr_pkg::DISC_CNT_W-1:0] disc_cnt_q;
	logic [31:0]                     lcg_q;
	logic                            out_valid_q;
	logic [30:0]                     value_q;

	logic [31:0] words [DEPTH];
	logic [31:0] sum_w;
	logic        in_acc, draw_acc, seed_acc, out_acc;
	logic        step_draw, step_fill;
	logic        fill_last, disc_last;

	// ring rotation with the lagged add
	assign sum_w = words[GAP] + words[0];

	assign out_acc  = out_valid_q && !out_stall;
	assign in_stall = (state_q != alfr_pkg::ST_RUN) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign draw_acc = in_acc && operation;
	assign seed_acc = in_acc && !operation;

	assign fill_last = (fill_cnt_q == alfr_pkg::FILL_CNT_W'(DEPTH - 1));
	assign disc_last = (disc_cnt_q == alfr_pkg::DISC_CNT_W'(alfr_pkg::DISCARD_COUNT - 1));

	// sequencer
	always_comb begin
		state_d   = state_q;
		step_draw = 1'b0;
		step_fill = 1'b0;
		unique case (state_q)
			alfr_pkg::ST_RUN: begin
				step_draw = draw_acc;
				if (seed_acc) begin
					state_d = alfr_pkg::ST_FILL;
				end
			end
			alfr_pkg::ST_FILL: begin
				step_fill = 1'b1;
				if (fill_last) begin
					state_d = (alfr_pkg::DISCARD_COUNT == 0) ? alfr_pkg::ST_RUN
						: alfr_pkg::ST_DISCARD;
				end
			end
			alfr_pkg::ST_DISCARD: begin
				step_draw = 1'b1;
				if (disc_last) begin
					state_d = alfr_pkg::ST_RUN;
				end
			end
			default: begin
				state_d = alfr_pkg::ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= alfr_pkg::ST_RUN;
			fill_cnt_q <= '0;
			disc_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (seed_acc) begin
				fill_cnt_q <= '0;
				disc_cnt_q <= '0;
			end else begin
				if (step_fill) begin
					fill_cnt_q <= fill_cnt_q + 1'b1;
				end
				if (state_q == alfr_pkg::ST_DISCARD) begin
					disc_cnt_q <= disc_cnt_q + 1'b1;
				end
			end
		end
	end

	// fill word generator: seed first, then prev * mul + add
	always_ff @(posedge clk) begin
		if (seed_acc) begin
			lcg_q <= seed;
		end else if (step_fill) begin
			lcg_q <= lcg_q * alfr_pkg::FILL_MUL + alfr_pkg::FILL_ADD;
		end
	end

	// the ring: cell i takes cell i+1; the last cell takes cell 0 (or the fill
	// word); cell GAP-1 takes the sum on a draw
	for (genvar i = 0; i < DEPTH; i++) begin : g_ring
		alfr_pkg::cell_ctl_t ctl;
		logic [31:0]         nb;

		assign ctl.shift_en = step_draw || step_fill;
		assign ctl.add_en   = (i == GAP - 1) && step_draw;

		if (i == DEPTH - 1) begin : g_tail
			assign nb = step_fill ? lcg_q : words[0];
		end else begin : g_body
			assign nb = words[i + 1];
		end

		alfr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.init_word (alfr_pkg::BOOT_WORDS[i]),
			.ctl       (ctl),
			.nb_word   (nb),
			.alt_word  (sum_w),
			.word      (words[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (draw_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_acc) begin
			value_q <= sum_w[31:1];
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for additive_lagged_fibonacci_rng_unit
// Drives draw and reseed words through the input channel with random gaps.
// Holds its own copy of the 31-word lag ring to predict every drawn value.
// Checks each value leaving the output channel, in order, under random stall.
// ----------------------------------------------------------------------------
module tb;

	// operation codes of the input word
	localparam logic OP_RESEED = 1'b0;
	localparam logic OP_DRAW   = 1'b1;

	localparam int MAX_WAIT     = 18;
	localparam int RANDOM_WORDS = 1200;
	localparam int DRAIN_CYCLES = 8;
	// an honest run ends well below this limit; leave lots of room
	localparam int CYCLE_LIMIT  = 600000;

	// ring contents right after reset, word 0 first
	localparam logic [31:0] POWER_ON_WORDS [alfr_pkg::TABLE_DEPTH] = '{
		-32'd1708027847, 32'd853131300,   -32'd1687801470, 32'd1570894658,
		-32'd566525472,  -32'd552964171,  -32'd251413502,  32'd1223901435,
		32'd1950999915,  -32'd1095640144, -32'd1420011240, -32'd1805298435,
		-32'd1943115761, -32'd348292705,  -32'd1323376457, 32'd759393158,
		-32'd630772182,  32'd361286280,   -32'd479628451,  -32'd1873857033,
		-32'd686452778,  32'd1873211473,  32'd1634626454,  -32'd1399525412,
		32'd910245779,   -32'd970800488,  -32'd173790536,  -32'd1970743429,
		-32'd173171442,  -32'd1986452981, 32'd670779321
	};

	// one row of the directed script; known = value typed in by hand
	typedef struct packed {
		logic        op;
		logic [31:0] seed;
		logic        known;
		logic [30:0] value;
	} script_row_t;

	localparam int SCRIPT_LEN = 24;

	// Opening rows: the first three draws after reset come straight off the
	// power-on words (3+0, 4+1, 5+2), with junk in the ignored seed field.
	// Then reseeds at the seed extremes, back-to-back reseeds, and draws.
	script_row_t script [SCRIPT_LEN] = '{
		'{OP_DRAW,   32'h0000_0000, 1'b1, 31'd2078917053},
		'{OP_DRAW,   32'hFFFF_FFFF, 1'b1, 31'd143302914},
		'{OP_DRAW,   32'h8000_0000, 1'b1, 31'd1027100827},
		'{OP_DRAW,   32'h7FFF_FFFF, 1'b0, 31'd0},
		'{OP_RESEED, 32'h0000_0000, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0},
		'{OP_DRAW,   32'h1234_5678, 1'b0, 31'd0},
		'{OP_RESEED, 32'hFFFF_FFFF, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0},
		'{OP_RESEED, 32'h8000_0000, 1'b0, 31'd0},
		'{OP_DRAW,   32'hFFFF_FFFF, 1'b0, 31'd0},
		'{OP_RESEED, 32'h7FFF_FFFF, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0},
		'{OP_RESEED, 32'h0000_0001, 1'b0, 31'd0},
		'{OP_RESEED, 32'hA5A5_A5A5, 1'b0, 31'd0},
		'{OP_DRAW,   32'h5A5A_5A5A, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0},
		'{OP_DRAW,   32'h0000_0000, 1'b0, 31'd0}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        operation = OP_DRAW;
	logic [31:0] seed      = 32'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [30:0] value;

	// predicted ring and its two taps
	logic [31:0] lag_words [alfr_pkg::TABLE_DEPTH];
	logic [4:0]  rear_at;
	logic [4:0]  front_at;

	logic [30:0] pending_values [$];  // drawn values not yet seen at the output
	logic [30:0] expected_value;

	int  error_count = 0;
	int  cycle_count = 0;
	bit  tx_calm     = 1'b0;          // sender runs without gaps while set
	bit  rx_calm     = 1'b0;          // receiver never stalls while set
	int  rx_hold     = 0;

	additive_lagged_fibonacci_rng_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.seed      (seed),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// ring predictor
	// ------------------------------------------------------------------
	function automatic void load_power_on();
		for (int k = 0; k < alfr_pkg::TABLE_DEPTH; k++)
			lag_words[k] = POWER_ON_WORDS[k];
		rear_at  = 5'd0;
		front_at = 5'(alfr_pkg::LAG_GAP);
	endfunction

	// front word += rear word, both taps step forward around the ring
	function automatic logic [30:0] draw_from_ring();
		logic [31:0] sum;
		sum = lag_words[front_at] + lag_words[rear_at];
		lag_words[front_at] = sum;
		rear_at  = (rear_at == alfr_pkg::TABLE_DEPTH - 1) ? 5'd0 : rear_at + 5'd1;
		front_at = (front_at == alfr_pkg::TABLE_DEPTH - 1) ? 5'd0 : front_at + 5'd1;
		return sum[31:1];
	endfunction

	// LCG fill from the seed, taps back home, then silent warm-up draws
	function automatic void reseed_ring(input logic [31:0] s);
		lag_words[0] = s;
		for (int k = 1; k < alfr_pkg::TABLE_DEPTH; k++)
			lag_words[k] = lag_words[k - 1] * alfr_pkg::FILL_MUL + alfr_pkg::FILL_ADD;
		rear_at  = 5'd0;
		front_at = 5'(alfr_pkg::LAG_GAP);
		for (int n = 0; n < alfr_pkg::DISCARD_COUNT; n++)
			void'(draw_from_ring());
	endfunction

	// ------------------------------------------------------------------
	// sender: one word per call, random lead-in gap, waits out in_stall
	// ------------------------------------------------------------------
	task automatic send_word(input logic op, input logic [31:0] sd,
			input logic known, input logic [30:0] known_value);
		int          gap;
		logic [30:0] predicted;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		seed      <= sd;
		// accepted at the first edge that sees in_stall low
		do @(posedge clk); while (in_stall);
		if (op == OP_DRAW) begin
			predicted = draw_from_ring();
			pending_values.push_back(known ? known_value : predicted);
		end else begin
			reseed_ring(sd);
		end
		// flip between gappy and back-to-back stretches now and then
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
	endtask

	// ------------------------------------------------------------------
	// receiver: checks every word taken, then stalls a random while
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_values.size() == 0) begin
					$error("value: expected none, got %0d", value);
					error_count++;
				end else begin
					expected_value = pending_values.pop_front();
					if (value !== expected_value) begin
						$error("value: expected %0d, got %0d", expected_value, value);
						error_count++;
					end
				end
				rx_hold = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 39) == 0)
					rx_calm = !rx_calm;
			end else if (rx_hold > 0) begin
				rx_hold--;
			end
			out_stall <= (rx_hold != 0);
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		logic        op;
		logic [31:0] sd;
		load_power_on();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_word(script[i].op, script[i].seed, script[i].known, script[i].value);

		// mostly draws; a reseed now and then, sometimes at a seed extreme
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			op = ($urandom_range(0, 24) == 0) ? OP_RESEED : OP_DRAW;
			sd = $urandom;
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: sd = 32'h0000_0000;
					1: sd = 32'hFFFF_FFFF;
					2: sd = 32'h8000_0000;
					default: sd = 32'h7FFF_FFFF;
				endcase
			end
			send_word(op, sd, 1'b0, 31'd0);
		end
		in_valid <= 1'b0;

		while (pending_values.size() != 0)
			@(posedge clk);
		// catch any stray word after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
